// ===== rtl/core/acmc_pkg.sv =====
// Shared types, constants and helpers for the Aho-Corasick match counter.
`timescale 1ns / 1ps
package acmc_pkg;

  localparam int unsigned Nodes    = 4096;
  localparam int unsigned Alphabet = 26;
  localparam int unsigned CntW     = 16;
  localparam int unsigned NodeW    = $clog2(Nodes);
  localparam int unsigned Slots    = Nodes * Alphabet;
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned SymW     = 5;
  localparam int unsigned EpochW   = 8;
  localparam int unsigned FifoW    = 1;

  localparam logic [1:0] OpPat   = 2'd0;
  localparam logic [1:0] OpText  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  typedef enum logic [1:0] {
    K_PAT   = 2'd0,
    K_TEXT  = 2'd1,
    K_CLEAR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [SymW-1:0]  sym;
    logic             last;
  } item_t;

  typedef struct packed {
    logic pop;
    logic sweeping;
  } back_stat_t;

  function automatic logic [SlotW-1:0] slot_base(input logic [NodeW-1:0] node);
    return SlotW'(node) * SlotW'(Alphabet);
  endfunction

endpackage

// ===== rtl/core/acmc_front.sv =====
// Front end: accepts requests, classifies the op and queues work for the back end.
`timescale 1ns / 1ps
module acmc_front import acmc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      op_i,
  input  logic [SymW-1:0] symbol_i,
  input  logic            last_i,
  input  back_stat_t      stat_i,
  output logic            item_valid_o,
  output item_t           item_o
);

  item_t            fifo_q [2];
  logic [FifoW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             accept, push, pop;
  item_t            new_item;

  assign busy         = (cnt_q == 2'd2) | stat_i.sweeping;
  assign accept       = start & ~busy;
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = fifo_q[rptr_q];
  assign pop          = stat_i.pop & item_valid_o;

  always_comb begin
    new_item.sym  = symbol_i;
    new_item.last = last_i;
    push          = accept;
    case (op_i)
      OpPat:   new_item.kind = K_PAT;
      OpText:  new_item.kind = K_TEXT;
      OpClear: new_item.kind = K_CLEAR;
      default: begin
        new_item.kind = K_PAT;
        push          = 1'b0;
      end
    endcase
  end

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= new_item;
    end
  end

endmodule

// ===== rtl/core/acmc_back.sv =====
// Back end: trie memories, failure-link build, text scan and clearing sweeps.
`timescale 1ns / 1ps
module acmc_back import acmc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  item_t           item_i,
  output back_stat_t      stat_o,
  output logic            result_valid_o,
  output logic [CntW-1:0] match_count_o,
  output logic            trie_overflowed_o
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_SWEEP  = 20'h00002,
    S_MSWEEP = 20'h00004,
    S_P_RD   = 20'h00008,
    S_P_CHK  = 20'h00010,
    S_P_LAST = 20'h00020,
    S_P_END  = 20'h00040,
    S_BR_RD  = 20'h00080,
    S_BR_CHK = 20'h00100,
    S_BQ_POP = 20'h00200,
    S_BQ_U   = 20'h00400,
    S_BQ_F   = 20'h00800,
    S_BC_RV  = 20'h01000,
    S_BC_RG  = 20'h02000,
    S_BC_W   = 20'h04000,
    S_T_RD   = 20'h08000,
    S_T_CHK  = 20'h10000,
    S_T_WALK = 20'h20000,
    S_T_WDAT = 20'h40000,
    S_T_END  = 20'h80000
  } state_e;

  logic [NodeW-1:0]  child_mem [Slots];
  logic [NodeW-1:0]  fail_mem  [Nodes];
  logic [CntW-1:0]   end_mem   [Nodes];
  logic [EpochW-1:0] mark_mem  [Nodes];
  logic [NodeW-1:0]  queue_mem [Nodes];

  logic              child_we, fail_we, end_we, mark_we, queue_we;
  logic [SlotW-1:0]  child_waddr, child_raddr;
  logic [NodeW-1:0]  child_wdata, child_rdata;
  logic [NodeW-1:0]  fail_waddr, fail_raddr, fail_wdata, fail_rdata;
  logic [NodeW-1:0]  end_waddr, end_raddr;
  logic [CntW-1:0]   end_wdata, end_rdata;
  logic [NodeW-1:0]  mark_waddr, mark_raddr;
  logic [EpochW-1:0] mark_wdata, mark_rdata;
  logic [NodeW-1:0]  queue_waddr, queue_raddr, queue_wdata, queue_rdata;

  state_e            state_q, state_d;
  item_t             cur_q, cur_d;
  logic [NodeW-1:0]  node_total_q, node_total_d, cursor_q, cursor_d;
  logic [NodeW-1:0]  head_q, head_d, tail_q, tail_d, j_q, j_d, v_q, v_d;
  logic [CntW-1:0]   match_q, match_d;
  logic              built_q, built_d, ovf_q, ovf_d, broken_q, broken_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic [SlotW-1:0]  cnt_q, cnt_d, slot_q, slot_d, base_u_q, base_u_d, base_f_q, base_f_d;
  logic [SymW-1:0]   c_q, c_d;
  logic              res_valid_q, res_valid_d, res_ovf_q, res_ovf_d;
  logic [CntW-1:0]   res_count_q, res_count_d;
  logic              sym_ok;

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  assign sym_ok            = cur_q.sym < SymW'(Alphabet);
  assign result_valid_o    = res_valid_q;
  assign match_count_o     = res_count_q;
  assign trie_overflowed_o = res_ovf_q;

  always_comb begin
    state_d         = state_q;
    cur_d           = cur_q;
    node_total_d    = node_total_q;
    cursor_d        = cursor_q;
    head_d          = head_q;
    tail_d          = tail_q;
    j_d             = j_q;
    v_d             = v_q;
    match_d         = match_q;
    built_d         = built_q;
    ovf_d           = ovf_q;
    broken_d        = broken_q;
    epoch_d         = epoch_q;
    cnt_d           = cnt_q;
    slot_d          = slot_q;
    base_u_d        = base_u_q;
    base_f_d        = base_f_q;
    c_d             = c_q;
    res_valid_d     = 1'b0;
    res_count_d     = res_count_q;
    res_ovf_d       = res_ovf_q;
    stat_o.pop      = 1'b0;
    stat_o.sweeping = state_q == S_SWEEP;
    child_we        = 1'b0;
    child_waddr     = cnt_q;
    child_wdata     = '0;
    child_raddr     = slot_base(cursor_q) + SlotW'(cur_q.sym);
    fail_we         = 1'b0;
    fail_waddr      = v_q;
    fail_wdata      = '0;
    fail_raddr      = j_q;
    end_we          = 1'b0;
    end_waddr       = cursor_q;
    end_wdata       = '0;
    end_raddr       = cursor_q;
    mark_we         = 1'b0;
    mark_waddr      = cnt_q[NodeW-1:0];
    mark_wdata      = '0;
    mark_raddr      = j_q;
    queue_we        = 1'b0;
    queue_waddr     = tail_q;
    queue_wdata     = v_q;
    queue_raddr     = head_q;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          stat_o.pop = 1'b1;
          cur_d      = item_i;
          case (item_i.kind)
            K_PAT:   state_d = built_q ? S_IDLE : S_P_RD;
            K_TEXT: begin
              if (built_q) begin
                state_d = S_T_RD;
              end else begin
                cursor_d = '0;
                broken_d = 1'b0;
                c_d      = '0;
                head_d   = '0;
                tail_d   = '0;
                state_d  = S_BR_RD;
              end
            end
            K_CLEAR: begin
              cnt_d        = '0;
              node_total_d = '0;
              cursor_d     = '0;
              match_d      = '0;
              built_d      = 1'b0;
              ovf_d        = 1'b0;
              broken_d     = 1'b0;
              epoch_d      = EpochW'(1);
              state_d      = S_SWEEP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        child_we = 1'b1;
        if (cnt_q < SlotW'(Nodes)) begin
          end_we    = 1'b1;
          end_waddr = cnt_q[NodeW-1:0];
          mark_we   = 1'b1;
        end
        if (cnt_q == SlotW'(Slots - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MSWEEP: begin
        mark_we = 1'b1;
        if (cnt_q[NodeW-1:0] == NodeW'(Nodes - 1)) begin
          epoch_d = EpochW'(1);
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_P_RD: begin
        slot_d = slot_base(cursor_q) + SlotW'(cur_q.sym);
        if (broken_q) begin
          state_d = S_P_LAST;
        end else if (!sym_ok) begin
          broken_d = 1'b1;
          state_d  = S_P_LAST;
        end else begin
          state_d = S_P_CHK;
        end
      end
      S_P_CHK: begin
        state_d = S_P_LAST;
        if (child_rdata != '0) begin
          cursor_d = child_rdata;
        end else if (node_total_q != NodeW'(Nodes - 1)) begin
          node_total_d = node_total_q + 1'b1;
          cursor_d     = node_total_q + 1'b1;
          child_we     = 1'b1;
          child_waddr  = slot_q;
          child_wdata  = node_total_q + 1'b1;
        end else begin
          ovf_d    = 1'b1;
          broken_d = 1'b1;
        end
      end
      S_P_LAST: begin
        if (!cur_q.last) begin
          state_d = S_IDLE;
        end else if (broken_q) begin
          cursor_d = '0;
          broken_d = 1'b0;
          state_d  = S_IDLE;
        end else begin
          state_d = S_P_END;
        end
      end
      S_P_END: begin
        end_we    = 1'b1;
        end_wdata = sat_add(end_rdata, CntW'(1));
        cursor_d  = '0;
        state_d   = S_IDLE;
      end
      S_BR_RD: begin
        child_raddr = SlotW'(c_q);
        state_d     = S_BR_CHK;
      end
      S_BR_CHK: begin
        if (child_rdata != '0) begin
          fail_we     = 1'b1;
          fail_waddr  = child_rdata;
          queue_we    = 1'b1;
          queue_wdata = child_rdata;
          tail_d      = tail_q + 1'b1;
        end
        if (c_q == SymW'(Alphabet - 1)) begin
          state_d = S_BQ_POP;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_BR_RD;
        end
      end
      S_BQ_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
          state_d = S_T_RD;
        end else begin
          state_d = S_BQ_U;
        end
      end
      S_BQ_U: begin
        head_d     = head_q + 1'b1;
        fail_raddr = queue_rdata;
        base_u_d   = slot_base(queue_rdata);
        state_d    = S_BQ_F;
      end
      S_BQ_F: begin
        base_f_d = slot_base(fail_rdata);
        c_d      = '0;
        state_d  = S_BC_RV;
      end
      S_BC_RV: begin
        child_raddr = base_u_q + SlotW'(c_q);
        state_d     = S_BC_RG;
      end
      S_BC_RG: begin
        v_d         = child_rdata;
        child_raddr = base_f_q + SlotW'(c_q);
        state_d     = S_BC_W;
      end
      S_BC_W: begin
        if (v_q != '0) begin
          fail_we    = 1'b1;
          fail_wdata = child_rdata;
          queue_we   = 1'b1;
          tail_d     = tail_q + 1'b1;
        end else begin
          child_we    = 1'b1;
          child_waddr = base_u_q + SlotW'(c_q);
          child_wdata = child_rdata;
        end
        if (c_q == SymW'(Alphabet - 1)) begin
          state_d = S_BQ_POP;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_BC_RV;
        end
      end
      S_T_RD: begin
        if (sym_ok) begin
          state_d = S_T_CHK;
        end else begin
          cursor_d = '0;
          j_d      = '0;
          state_d  = S_T_WALK;
        end
      end
      S_T_CHK: begin
        cursor_d = child_rdata;
        j_d      = child_rdata;
        state_d  = S_T_WALK;
      end
      S_T_WALK: begin
        end_raddr = j_q;
        state_d   = (j_q == '0) ? S_T_END : S_T_WDAT;
      end
      S_T_WDAT: begin
        if (mark_rdata == epoch_q) begin
          state_d = S_T_END;
        end else begin
          match_d    = sat_add(match_q, end_rdata);
          mark_we    = 1'b1;
          mark_waddr = j_q;
          mark_wdata = epoch_q;
          j_d        = fail_rdata;
          state_d    = S_T_WALK;
        end
      end
      S_T_END: begin
        state_d = S_IDLE;
        if (cur_q.last) begin
          res_valid_d = 1'b1;
          res_count_d = match_q;
          res_ovf_d   = ovf_q;
          cursor_d    = '0;
          match_d     = '0;
          if (epoch_q == {EpochW{1'b1}}) begin
            cnt_d   = '0;
            state_d = S_MSWEEP;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      cnt_q        <= '0;
      node_total_q <= '0;
      cursor_q     <= '0;
      match_q      <= '0;
      built_q      <= 1'b0;
      ovf_q        <= 1'b0;
      broken_q     <= 1'b0;
      epoch_q      <= EpochW'(1);
      head_q       <= '0;
      tail_q       <= '0;
      c_q          <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      node_total_q <= node_total_d;
      cursor_q     <= cursor_d;
      match_q      <= match_d;
      built_q      <= built_d;
      ovf_q        <= ovf_d;
      broken_q     <= broken_d;
      epoch_q      <= epoch_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      c_q          <= c_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    j_q         <= j_d;
    v_q         <= v_d;
    slot_q      <= slot_d;
    base_u_q    <= base_u_d;
    base_f_q    <= base_f_d;
    res_count_q <= res_count_d;
    res_ovf_q   <= res_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    child_rdata <= child_mem[child_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rdata <= fail_mem[fail_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (end_we) begin
      end_mem[end_waddr] <= end_wdata;
    end
    end_rdata <= end_mem[end_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rdata <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_waddr] <= queue_wdata;
    end
    queue_rdata <= queue_mem[queue_raddr];
  end

endmodule

// ===== rtl/core/aho_corasick_match_counter_core.sv =====
// Top level of the Aho-Corasick match counter: front queue plus back-end engine.
`timescale 1ns / 1ps
// Requests are taken when start is high and busy is low; a two-entry queue
// decouples intake from the engine, so requests are taken while earlier work
// runs. A text symbol takes longer for each newly visited fail-chain node;
// the first text symbol after loading also builds the automaton, which takes
// longer the more trie nodes there are. After reset and after each clear
// request a clearing pass runs with busy high. Every 255th text end adds a
// sweep of the visit marks. A result is shown for exactly one cycle on
// result_valid_o and cannot be stalled.
module aho_corasick_match_counter_core import acmc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      op_i,
  input  logic [SymW-1:0] symbol_i,
  input  logic            last_i,
  output logic            result_valid_o,
  output logic [CntW-1:0] match_count_o,
  output logic            trie_overflowed_o
);

  back_stat_t stat;
  logic       item_valid;
  item_t      item;

  acmc_front u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .op_i,
    .symbol_i,
    .last_i,
    .stat_i       (stat),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  acmc_back u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .stat_o       (stat),
    .result_valid_o,
    .match_count_o,
    .trie_overflowed_o
  );

  a_no_result_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !stat.sweeping)
    else $error("result during clearing pass");

  a_busy_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.sweeping |-> busy)
    else $error("request window open during clearing pass");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

endmodule

// ===== test/tb_aho_corasick_match_counter_core.sv =====
// Testbench for the Aho-Corasick match counter: random requests checked against a predictor.
`timescale 1ns / 1ps

import acmc_pkg::*;

class acmc_scoreboard;

  typedef struct {
    logic [CntW-1:0] count;
    logic            ovf;
  } tally_t;

  int unsigned goto_tbl[Slots];
  int unsigned fail_tbl[Nodes];
  int unsigned hits_at[Nodes];
  bit          seen[Nodes];
  int unsigned walk_q[Nodes];
  int unsigned n_nodes, cur, total;
  bit          built, ovf, broken;
  tally_t      tally_q[$];
  int unsigned errors;

  function new();
    errors = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (goto_tbl[i]) goto_tbl[i] = 0;
    foreach (fail_tbl[i]) begin
      fail_tbl[i] = 0;
      hits_at[i] = 0;
      seen[i] = 0;
    end
    n_nodes = 0;
    cur = 0;
    total = 0;
    built = 0;
    ovf = 0;
    broken = 0;
  endfunction

  function int unsigned sat(int unsigned a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > (2**CntW - 1)) ? (2**CntW - 1) : s;
  endfunction

  function void build();
    int unsigned head, tail, u, f, v, g;
    head = 0;
    tail = 0;
    for (int c = 0; c < Alphabet; c++) begin
      v = goto_tbl[c];
      if (v != 0 && tail < Nodes) begin
        fail_tbl[v] = 0;
        walk_q[tail++] = v;
      end
    end
    while (head < tail) begin
      u = walk_q[head++];
      f = fail_tbl[u];
      for (int c = 0; c < Alphabet; c++) begin
        v = goto_tbl[u * Alphabet + c];
        g = goto_tbl[f * Alphabet + c];
        if (v != 0) begin
          fail_tbl[v] = g;
          if (tail < Nodes) walk_q[tail++] = v;
        end else begin
          goto_tbl[u * Alphabet + c] = g;
        end
      end
    end
    built = 1;
  endfunction

  function void load(int unsigned sym, bit lst);
    int unsigned v;
    if (!broken) begin
      if (sym >= Alphabet) begin
        broken = 1;
      end else begin
        v = goto_tbl[cur * Alphabet + sym];
        if (v == 0) begin
          if (n_nodes + 1 < Nodes) begin
            n_nodes++;
            v = n_nodes;
            goto_tbl[cur * Alphabet + sym] = v;
          end else begin
            ovf = 1;
            broken = 1;
          end
        end
        if (!broken) cur = v;
      end
    end
    if (lst) begin
      if (!broken) hits_at[cur] = sat(hits_at[cur], 1);
      cur = 0;
      broken = 0;
    end
  endfunction

  function void note(logic [1:0] op, logic [SymW-1:0] sym, logic lst);
    int unsigned j;
    tally_t t;
    if (op == OpClear) begin
      wipe();
    end else if (op == OpPat) begin
      if (!built) load(sym, lst);
    end else if (op == OpText) begin
      if (!built) begin
        cur = 0;
        broken = 0;
        build();
      end
      cur = (sym < Alphabet) ? goto_tbl[cur * Alphabet + sym] : 0;
      j = cur;
      while (j != 0 && j < Nodes && !seen[j]) begin
        total = sat(total, hits_at[j]);
        seen[j] = 1;
        j = fail_tbl[j];
      end
      if (lst) begin
        t.count = total[CntW-1:0];
        t.ovf = ovf;
        tally_q.push_back(t);
        cur = 0;
        total = 0;
        foreach (seen[i]) seen[i] = 0;
      end
    end
  endfunction

  function void check(logic [CntW-1:0] count, logic ovf_o);
    tally_t t;
    if (tally_q.size() == 0) begin
      $display("%0t: result with none expected, count %0d ovf %0b", $time, count, ovf_o);
      errors++;
      return;
    end
    t = tally_q.pop_front();
    if (count !== t.count) begin
      $display("%0t: match_count expected %0d actual %0d", $time, t.count, count);
      errors++;
    end
    if (ovf_o !== t.ovf) begin
      $display("%0t: trie_overflowed expected %0b actual %0b", $time, t.ovf, ovf_o);
      errors++;
    end
  endfunction
endclass

module tb_aho_corasick_match_counter_core;
  import acmc_pkg::*;

  localparam int unsigned WatchLimit = 2000000;

  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            start = 0;
  logic            busy;
  logic [1:0]      op_i = OpPat;
  logic [SymW-1:0] symbol_i = '0;
  logic            last_i = 0;
  logic            result_valid_o;
  logic [CntW-1:0] match_count_o;
  logic            trie_overflowed_o;

  acmc_scoreboard sb = new();
  int unsigned    idle_cycles = 0;
  int unsigned    burst_left = 0;
  int unsigned    sent = 0;

  aho_corasick_match_counter_core dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (result_valid_o) sb.check(match_count_o, trie_overflowed_o);
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic gap_maybe();
    int unsigned g;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    if ($urandom_range(0, 3) != 0) begin
      g = $urandom_range(1, 6);
      start <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send(logic [1:0] op, logic [SymW-1:0] sym, logic lst);
    start <= 1;
    op_i <= op;
    symbol_i <= sym;
    last_i <= lst;
    do @(posedge clk_i); while (busy);
    sb.note(op, sym, lst);
    sent++;
    gap_maybe();
  endtask

  task automatic send_word(logic [1:0] op, string s);
    for (int i = 0; i < s.len(); i++)
      send(op, SymW'(s[i] - "a"), i == s.len() - 1);
  endtask

  function automatic logic [SymW-1:0] pick_sym();
    if ($urandom_range(0, 19) == 0) return SymW'($urandom_range(0, 31));
    return SymW'($urandom_range(0, 3));
  endfunction

  task automatic rand_phase(int unsigned n_items);
    int unsigned npat, len, stop;
    npat = $urandom_range(4, 12);
    for (int p = 0; p < npat; p++) begin
      len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++) send(OpPat, pick_sym(), k == len - 1);
      if ($urandom_range(0, 15) == 0) send(OpNone, SymW'($urandom), 1'($urandom));
    end
    stop = sent + n_items;
    while (sent < stop) begin
      case ($urandom_range(0, 39))
        0: send(OpPat, SymW'($urandom), 1'($urandom));
        1: send(OpNone, SymW'($urandom), 1'($urandom));
        default: send(OpText, pick_sym(), $urandom_range(0, 5) == 0);
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // overlapping patterns, duplicates, broken pattern, idle op code
    send_word(OpPat, "ab");
    send_word(OpPat, "b");
    send_word(OpPat, "ab");
    send(OpPat, 5'd0, 1'b0);
    send(OpPat, 5'd31, 1'b0);
    send(OpPat, 5'd1, 1'b1);
    send(OpNone, 5'd31, 1'b1);
    send_word(OpPat, "za");
    send(OpText, 5'd25, 1'b0);
    send(OpText, 5'd26, 1'b0);
    send_word(OpText, "zab");
    send(OpPat, 5'd2, 1'b1);
    send_word(OpText, "abab");
    send(OpText, 5'd31, 1'b1);

    rand_phase(620);
    send(OpClear, 5'd0, 1'b0);
    rand_phase(620);
    send(OpClear, 5'd31, 1'b1);
    rand_phase(550);

    // fresh automaton after a clear
    send(OpClear, 5'd0, 1'b0);
    send_word(OpPat, "b");
    send_word(OpText, "ab");

    start <= 0;
    wait (sb.tally_q.size() == 0);
    repeat (10000) @(posedge clk_i);
    if (sb.errors == 0 && sb.tally_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
